// ----- rtl/modulated_delay_chorus_assert.svh -----
// ----------------------------------------------------------------------------
// modulated delay chorus assertion macros
// concurrent checks on the rising clock edge, off under synthesis
// ----------------------------------------------------------------------------
`ifndef MODULATED_DELAY_CHORUS_ASSERT_SVH
`define MODULATED_DELAY_CHORUS_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold outside reset
`define MDC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define MDC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MDC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/mdc_pkg.sv -----
// ----------------------------------------------------------------------------
// mdc_pkg
// shared widths, constants, register indexes and control types of the chorus
// ----------------------------------------------------------------------------
`default_nettype none

package mdc_pkg;

  localparam int LineDepthDef = 4096;

  localparam int SampleW  = 16;
  localparam int LenCfgW  = 13;
  localparam int DepthW   = 20;
  localparam int MixW     = 16;
  localparam int FracW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 20;

  localparam logic [LenCfgW-1:0] LineLengthRst = 13'd1323;
  localparam logic [DepthW-1:0]  DepthQ8Rst    = 20'd112896;
  localparam logic [MixW-1:0]    MixRst        = 16'd9830;

  localparam logic [MixW-1:0]    MixFull = 16'd32768;
  localparam logic [FracW:0]     FracOne = 9'd256;
  localparam int                 LenMin  = 2;

  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_LENGTH = 2'd0,
    REG_DEPTH_Q8    = 2'd1,
    REG_MIX         = 2'd2
  } mdc_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SAT,
    ST_MOD1,
    ST_MOD2,
    ST_RDA,
    ST_RDB,
    ST_WET,
    ST_MIX,
    ST_OUT
  } mdc_state_e;

  typedef struct packed {
    logic ld_in;
    logic ld_prod;
    logic ld_sat;
    logic ld_mod1;
    logic ld_mod2;
    logic rd_a;
    logic rd_b;
    logic ld_wet;
    logic ld_acc;
    logic ld_out;
  } mdc_cmd_t;

  typedef struct packed {
    logic out_free;
  } mdc_sts_t;

endpackage

`default_nettype wire

// ----- rtl/mdc_in_if.sv -----
// ----------------------------------------------------------------------------
// mdc_in_if
// input channel of the chorus: dry sample and lfo value per item
// ----------------------------------------------------------------------------
`default_nettype none

interface mdc_in_if;
  import mdc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] dry_sample;
  logic signed [SampleW-1:0] lfo_value;

  modport source (output valid, output dry_sample, output lfo_value, input ready);
  modport sink   (input valid, input dry_sample, input lfo_value, output ready);

endinterface

`default_nettype wire

// ----- rtl/mdc_out_if.sv -----
// ----------------------------------------------------------------------------
// mdc_out_if
// output channel of the chorus: one mixed sample per item
// ----------------------------------------------------------------------------
`default_nettype none

interface mdc_out_if;
  import mdc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] mixed_sample;

  modport source (output valid, output mixed_sample, input ready);
  modport sink   (input valid, input mixed_sample, output ready);

endinterface

`default_nettype wire

// ----- rtl/modulated_delay_chorus.sv -----
// ----------------------------------------------------------------------------
// modulated_delay_chorus
// chorus with lfo modulated delay line, linear interpolation and dry/wet mix
//
//   port     dir  payload                       handshake
//   in_i     in   dry_sample, lfo_value         valid/ready
//   out_o    out  mixed_sample                  valid/ready
//   cfg_*    in   line_length, depth_q8, mix    write enable only
//
// an item passes through the sequencer steps from accept to result:
// multiply, saturate, two modulo steps, two ring reads, interpolate, blend
// a finished result waits in the output register while the next item enters
// a result not taken stalls the sequencer in its last step
// reset needs no clearing pass: a fill level marks unwritten ring entries
// ----------------------------------------------------------------------------
`default_nettype none
`include "modulated_delay_chorus_assert.svh"

module modulated_delay_chorus #(
  parameter int LINE_DEPTH = mdc_pkg::LineDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  mdc_in_if.sink                            in_i,
  mdc_out_if.source                         out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [mdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mdc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import mdc_pkg::*;

  mdc_cmd_t cmd;
  mdc_sts_t sts;
  logic     in_ready;
  logic     out_valid;
  logic signed [SampleW-1:0] mixed_sample;

  mdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mdc_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .dry_sample_i   (in_i.dry_sample),
    .lfo_value_i    (in_i.lfo_value),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_valid),
    .mixed_sample_o (mixed_sample),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid;
  assign out_o.mixed_sample = mixed_sample;

  `MDC_ASSERT(a_accept_starts_mul, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> (cmd.ld_prod && !in_i.ready), "accepted item did not start the multiply step")
  `MDC_ASSERT(a_load_gives_valid, clk_i, rst_ni, cmd.ld_out |=> out_o.valid, "loaded result not presented")
  `MDC_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.ld_out && !sts.out_free, "result register overwritten while held")

endmodule

`default_nettype wire

// ----- rtl/mdc_ram.sv -----
// ----------------------------------------------------------------------------
// mdc_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/mdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mdc_ctrl
// sequencer of the chorus: walks one item through the datapath steps
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire mdc_pkg::mdc_sts_t sts_i,
  output      mdc_pkg::mdc_cmd_t cmd_o
);
  import mdc_pkg::*;

  mdc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.ld_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.ld_prod = 1'b1;
        state_d       = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.ld_sat = 1'b1;
        state_d      = ST_MOD1;
      end
      ST_MOD1: begin
        cmd_o.ld_mod1 = 1'b1;
        state_d       = ST_MOD2;
      end
      ST_MOD2: begin
        cmd_o.ld_mod2 = 1'b1;
        state_d       = ST_RDA;
      end
      ST_RDA: begin
        cmd_o.rd_a = 1'b1;
        state_d    = ST_RDB;
      end
      ST_RDB: begin
        cmd_o.rd_b = 1'b1;
        state_d    = ST_WET;
      end
      ST_WET: begin
        cmd_o.ld_wet = 1'b1;
        state_d      = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.ld_acc = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mdc_dp.sv -----
// ----------------------------------------------------------------------------
// mdc_dp
// chorus datapath: config registers, delay math, ring memory and output stage
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_dp #(
  parameter int LINE_DEPTH = mdc_pkg::LineDepthDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [mdc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [mdc_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  wire logic signed [mdc_pkg::SampleW-1:0] dry_sample_i,
  input  wire logic signed [mdc_pkg::SampleW-1:0] lfo_value_i,
  input  wire logic                               out_ready_i,
  output      logic                               out_valid_o,
  output      logic signed [mdc_pkg::SampleW-1:0] mixed_sample_o,
  input  wire mdc_pkg::mdc_cmd_t                  cmd_i,
  output      mdc_pkg::mdc_sts_t                  sts_o
);
  import mdc_pkg::*;

  localparam int AW    = $clog2(LINE_DEPTH);
  localparam int LW    = AW + 1;
  localparam int CW    = ((LW > LenCfgW) ? LW : LenCfgW) + 1;
  localparam int ProdW = DepthW + 1 + SampleW;
  localparam int WholeW = ProdW - 15 - FracW;
  localparam int SW    = ((LW + 1 > WholeW) ? LW + 1 : WholeW) + 1;
  localparam int TW    = LW + 3;
  localparam int WetW  = SampleW + FracW + 2;
  localparam int AccW  = MixW + 1 + WetW + 1;
  localparam int ResW  = AccW - 23;

  // configuration registers
  logic [LenCfgW-1:0] line_length_q;
  logic [DepthW-1:0]  depth_q8_q;
  logic [MixW-1:0]    mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= LineLengthRst;
      depth_q8_q    <= DepthQ8Rst;
      mix_q         <= MixRst;
    end else if (cfg_we_i) begin
      unique case (mdc_reg_e'(cfg_idx_i))
        REG_LINE_LENGTH: line_length_q <= cfg_wdata_i[LenCfgW-1:0];
        REG_DEPTH_Q8:    depth_q8_q    <= cfg_wdata_i[DepthW-1:0];
        REG_MIX:         mix_q         <= cfg_wdata_i[MixW-1:0];
        default: ;
      endcase
    end
  end

  // ring state
  logic [AW-1:0] wp_q;
  logic [LW-1:0] fill_q;

  // item registers
  logic signed [SampleW-1:0] dry_q, lfo_q;
  logic [LW-1:0]             len_q;
  logic [MixW-1:0]           m_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [LW:0]        whole_sat_q;
  logic [FracW-1:0]          frac_q;
  logic [TW-1:0]             t1_q;
  logic [AW-1:0]             rd_q, prev_q;
  logic                      hit_rd_q, hit_prev_q;
  logic signed [SampleW-1:0] s_rd_q;
  logic signed [WetW-1:0]    wet_q;
  logic signed [AccW-1:0]    acc_q;
  logic signed [SampleW-1:0] out_q;
  logic                      out_valid_q;

  // effective line length and mix
  logic [CW-1:0]   ll_x, depth_x;
  logic [LW-1:0]   len_d;
  logic [MixW-1:0] m_d;

  assign ll_x    = {{(CW-LenCfgW){1'b0}}, line_length_q};
  assign depth_x = CW'(LINE_DEPTH);
  assign len_d   = (ll_x > depth_x) ? LW'(LINE_DEPTH)
                 : (ll_x < CW'(LenMin)) ? LW'(LenMin)
                 : ll_x[LW-1:0];
  assign m_d     = (mix_q > MixFull) ? MixFull : mix_q;

  // delay saturation
  logic signed [WholeW-1:0] whole;
  logic [LW-1:0]            lim;
  logic signed [SW-1:0]     whole_x, lim_x, nlim_x;
  logic signed [LW:0]       whole_sat_d;
  logic [FracW-1:0]         frac_d;

  assign whole   = $signed(prod_q[ProdW-1:15+FracW]);
  assign lim     = len_q - LW'(1);
  assign whole_x = {{(SW-WholeW){whole[WholeW-1]}}, whole};
  assign lim_x   = $signed({{(SW-LW){1'b0}}, lim});
  assign nlim_x  = -lim_x;

  always_comb begin
    whole_sat_d = whole_x[LW:0];
    frac_d      = prod_q[15+FracW-1:15];
    if (whole_x > lim_x) begin
      whole_sat_d = lim_x[LW:0];
      frac_d      = '0;
    end else if (whole_x < nlim_x) begin
      whole_sat_d = nlim_x[LW:0];
      frac_d      = '0;
    end
  end

  // read index modulo line length
  logic [TW-1:0] len_t, t0, t1_d, rd_full;
  logic [LW-1:0] wp_x, rd_x, prev_x, wp_inc;

  assign len_t   = {{(TW-LW){1'b0}}, len_q};
  assign t0      = {{(TW-AW){1'b0}}, wp_q} + len_t
                 - {{(TW-LW-1){whole_sat_q[LW]}}, whole_sat_q};
  assign t1_d    = (t0 >= len_t) ? t0 - len_t : t0;
  assign rd_full = (t1_q >= len_t) ? t1_q - len_t : t1_q;
  assign wp_x    = {1'b0, wp_q};
  assign rd_x    = {1'b0, rd_q};
  assign prev_x  = {1'b0, prev_q};
  assign wp_inc  = wp_x + LW'(1);

  // ring memory
  logic [SampleW-1:0] ram_rdata;

  mdc_ram #(
    .WIDTH (SampleW),
    .DEPTH (LINE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ld_out),
    .waddr_i (wp_q),
    .wdata_i (dry_q),
    .re_i    (cmd_i.rd_a | cmd_i.rd_b),
    .raddr_i (cmd_i.rd_b ? prev_q : rd_q),
    .rdata_o (ram_rdata)
  );

  // interpolation and blend
  logic signed [SampleW-1:0] s_prev;
  logic [FracW:0]            w_rd;
  logic [MixW-1:0]           dmix;
  logic signed [WetW-1:0]    wet_d;
  logic signed [AccW-1:0]    acc_d;
  logic signed [ResW-1:0]    res;
  logic signed [SampleW-1:0] res_sat;

  assign s_prev = hit_prev_q ? $signed(ram_rdata) : '0;
  assign w_rd   = FracOne - {1'b0, frac_q};
  assign wet_d  = WetW'($signed({1'b0, w_rd})) * WetW'(s_rd_q)
                + WetW'($signed({1'b0, frac_q})) * WetW'(s_prev);
  assign dmix   = MixFull - m_q;
  assign acc_d  = ((AccW'($signed({1'b0, dmix})) * AccW'(dry_q)) <<< FracW)
                + (AccW'($signed({1'b0, m_q})) * AccW'(wet_q));
  assign res    = acc_q[AccW-1:23];

  always_comb begin
    res_sat = res[SampleW-1:0];
    if (res > SampleMax) begin
      res_sat = SampleMax;
    end else if (res < SampleMin) begin
      res_sat = SampleMin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      dry_q <= dry_sample_i;
      lfo_q <= lfo_value_i;
      len_q <= len_d;
      m_q   <= m_d;
    end
    if (cmd_i.ld_prod) begin
      prod_q <= ProdW'($signed({1'b0, depth_q8_q})) * ProdW'(lfo_q);
    end
    if (cmd_i.ld_sat) begin
      whole_sat_q <= whole_sat_d;
      frac_q      <= frac_d;
    end
    if (cmd_i.ld_mod1) begin
      t1_q <= t1_d;
    end
    if (cmd_i.ld_mod2) begin
      rd_q <= rd_full[AW-1:0];
    end
    if (cmd_i.rd_a) begin
      prev_q   <= (rd_q == '0) ? lim[AW-1:0] : rd_q - AW'(1);
      hit_rd_q <= rd_x < fill_q;
    end
    if (cmd_i.rd_b) begin
      s_rd_q     <= hit_rd_q ? $signed(ram_rdata) : '0;
      hit_prev_q <= prev_x < fill_q;
    end
    if (cmd_i.ld_wet) begin
      wet_q <= wet_d;
    end
    if (cmd_i.ld_acc) begin
      acc_q <= acc_d;
    end
    if (cmd_i.ld_out) begin
      out_q <= res_sat;
    end
  end

  // write position and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (cmd_i.ld_prod) begin
      if (wp_x >= len_q) begin
        wp_q <= '0;
      end
    end else if (cmd_i.ld_out) begin
      wp_q <= (wp_inc == len_q) ? '0 : wp_inc[AW-1:0];
      if (wp_inc > fill_q) begin
        fill_q <= wp_inc;
      end
    end
  end

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = out_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire
